// ----- rtl/core/elastic_collision_impulse_assert.svh -----
// assertion macros for the contact impulse block
`ifndef ELASTIC_COLLISION_IMPULSE_ASSERT_SVH
`define ELASTIC_COLLISION_IMPULSE_ASSERT_SVH

// same-cycle implication
`define ECI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/eci_pkg.sv -----
// types, constants and arithmetic helpers for the contact impulse block
`default_nettype none
package eci_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = 32;
    localparam int SAT_BITS  = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
    localparam int DEN_W     = FIELD_W + 1;
    localparam int NUM_W     = FIELD_W + 1 + FRAC_BITS;
    localparam int DIV_STEPS = NUM_W;
    localparam int PROD_W    = 2 * FIELD_W + 1;
    localparam int WIDE_W    = PROD_W + 1;

    localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) << (SAT_BITS - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

    typedef enum logic [1:0] {
        OUT_SEP = 2'd0,
        OUT_IMP = 2'd1,
        OUT_COR = 2'd2,
        OUT_DEG = 2'd3
    } t_outcome;

    typedef logic signed [FIELD_W-1:0] t_sq;
    typedef logic        [FIELD_W-1:0] t_uq;

    typedef struct packed {
        t_sq vel_a_x;
        t_sq vel_a_y;
        t_sq vel_b_x;
        t_sq vel_b_y;
        t_sq normal_x;
        t_sq normal_y;
        t_sq depth;
        t_uq mass_a;
        t_uq mass_b;
        t_uq inv_mass_a;
        t_uq inv_mass_b;
    } t_in;

    typedef struct packed {
        t_outcome outcome;
        t_sq      new_vel_a_x;
        t_sq      new_vel_a_y;
        t_sq      new_vel_b_x;
        t_sq      new_vel_b_y;
        t_sq      shift_a_x;
        t_sq      shift_a_y;
        t_sq      shift_b_x;
        t_sq      shift_b_y;
    } t_out;

    typedef struct packed {
        t_outcome kind;
        t_sq      vax;
        t_sq      vay;
        t_sq      vbx;
        t_sq      vby;
        t_sq      nx;
        t_sq      ny;
        t_sq      dep;
        t_uq      ia;
        t_uq      ib;
    } t_side;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] acc;
    } t_div_st;

    function automatic t_sq sat(input logic signed [WIDE_W-1:0] x);
        t_sq r;
        if (x > SAT_HI) begin
            r = SAT_HI[FIELD_W-1:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[FIELD_W-1:0];
        end else begin
            r = x[FIELD_W-1:0];
        end
        return r;
    endfunction

    // floor shift of a q x q product, then saturate
    function automatic t_sq qsat(input logic signed [PROD_W-1:0] p);
        return sat(WIDE_W'(p >>> FRAC_BITS));
    endfunction

    function automatic logic signed [PROD_W-1:0] smul(input t_sq a,
                                                      input logic signed [FIELD_W:0] b);
        return a * b;
    endfunction

    // one restoring division step
    function automatic t_div_st div_step(input t_div_st s, input logic [DEN_W-1:0] d);
        logic [DEN_W:0]   sh;
        logic [DEN_W+1:0] trial;
        t_div_st          r;
        sh    = {s.rem, s.acc[NUM_W-1]};
        trial = {1'b0, sh} - {2'b00, d};
        r.acc = {s.acc[NUM_W-2:0], ~trial[DEN_W+1]};
        r.rem = trial[DEN_W+1] ? sh[DEN_W-1:0] : trial[DEN_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/eci_div.sv -----
// pipelined dual restoring divider, one quotient bit per stage, with sideband
`default_nettype none
module eci_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire eci_pkg::t_side              i_side,
    input  wire logic [eci_pkg::NUM_W-1:0]   i_num1,
    input  wire logic [eci_pkg::DEN_W-1:0]   i_den1,
    input  wire logic [eci_pkg::NUM_W-1:0]   i_num2,
    input  wire logic [eci_pkg::DEN_W-1:0]   i_den2,
    output logic                             o_valid,
    output eci_pkg::t_side                   o_side,
    output logic [eci_pkg::NUM_W-1:0]        o_quo1,
    output logic [eci_pkg::NUM_W-1:0]        o_quo2
);

    logic                         r_vld  [eci_pkg::DIV_STEPS];
    eci_pkg::t_div_st             r_l1   [eci_pkg::DIV_STEPS];
    eci_pkg::t_div_st             r_l2   [eci_pkg::DIV_STEPS];
    logic [eci_pkg::DEN_W-1:0]    r_d1   [eci_pkg::DIV_STEPS];
    logic [eci_pkg::DEN_W-1:0]    r_d2   [eci_pkg::DIV_STEPS];
    eci_pkg::t_side               r_side [eci_pkg::DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < eci_pkg::DIV_STEPS; k++) begin : g_step
            logic                      v_in;
            eci_pkg::t_div_st          s1_in;
            eci_pkg::t_div_st          s2_in;
            logic [eci_pkg::DEN_W-1:0] d1_in;
            logic [eci_pkg::DEN_W-1:0] d2_in;
            eci_pkg::t_side            side_in;

            if (k == 0) begin : g_first
                assign v_in    = i_valid;
                assign s1_in   = {{eci_pkg::DEN_W{1'b0}}, i_num1};
                assign s2_in   = {{eci_pkg::DEN_W{1'b0}}, i_num2};
                assign d1_in   = i_den1;
                assign d2_in   = i_den2;
                assign side_in = i_side;
            end else begin : g_next
                assign v_in    = r_vld[k-1];
                assign s1_in   = r_l1[k-1];
                assign s2_in   = r_l2[k-1];
                assign d1_in   = r_d1[k-1];
                assign d2_in   = r_d2[k-1];
                assign side_in = r_side[k-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_l1[k]   <= eci_pkg::div_step(s1_in, d1_in);
                    r_l2[k]   <= eci_pkg::div_step(s2_in, d2_in);
                    r_d1[k]   <= d1_in;
                    r_d2[k]   <= d2_in;
                    r_side[k] <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[eci_pkg::DIV_STEPS-1];
    assign o_side  = r_side[eci_pkg::DIV_STEPS-1];
    assign o_quo1  = r_l1[eci_pkg::DIV_STEPS-1].acc;
    assign o_quo2  = r_l2[eci_pkg::DIV_STEPS-1].acc;

endmodule
`default_nettype wire

// ----- rtl/core/elastic_collision_impulse.sv -----
// elastic contact impulse and position correction for one 2d contact pair per transaction
// pipeline from input acceptance to o_valid: 3 front stages, 49 divider stages, 5 back
// stages; throughput: one transaction per cycle when not stalled, set by the bit-per-stage divider
// a stall at the output holds the whole pipeline; no transaction is lost or repeated
// reset clears the valid bits of every stage only; payload registers are not reset
`default_nettype none
`include "elastic_collision_impulse_assert.svh"
module elastic_collision_impulse (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire eci_pkg::t_in   i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output eci_pkg::t_out       o_data
);

    logic w_en;

    // front stages
    logic                                r1_vld;
    eci_pkg::t_in                        r1_in;
    eci_pkg::t_sq                        r1_rvx;
    eci_pkg::t_sq                        r1_rvy;
    logic                                r2_vld;
    eci_pkg::t_in                        r2_in;
    logic signed [eci_pkg::PROD_W-1:0]   r2_px;
    logic signed [eci_pkg::PROD_W-1:0]   r2_py;
    logic                                r3_vld;
    eci_pkg::t_in                        r3_in;
    eci_pkg::t_sq                        r3_rel;

    // divider feed
    eci_pkg::t_side                      n_side;
    logic [eci_pkg::NUM_W-1:0]           n_num1;
    logic [eci_pkg::NUM_W-1:0]           n_num2;
    logic [eci_pkg::DEN_W-1:0]           n_den1;
    logic [eci_pkg::DEN_W-1:0]           n_den2;
    logic [eci_pkg::DEN_W-1:0]           w_den;
    logic [eci_pkg::DEN_W-1:0]           w_tot;
    logic [eci_pkg::FIELD_W:0]           w_negrel;

    logic                                w_dv_vld;
    eci_pkg::t_side                      w_dv_side;
    logic [eci_pkg::NUM_W-1:0]           w_q1;
    logic [eci_pkg::NUM_W-1:0]           w_q2;

    // back stages
    logic                                r5_vld;
    eci_pkg::t_side                      r5_side;
    logic signed [eci_pkg::PROD_W-1:0]   r5_m0;
    logic signed [eci_pkg::PROD_W-1:0]   r5_m1;
    logic signed [eci_pkg::PROD_W-1:0]   n5_m0;
    logic signed [eci_pkg::PROD_W-1:0]   n5_m1;
    eci_pkg::t_uq                        w_mag;
    logic                                r6_vld;
    eci_pkg::t_side                      r6_side;
    eci_pkg::t_sq                        r6_j0;
    eci_pkg::t_sq                        r6_j1;
    logic                                r7_vld;
    eci_pkg::t_side                      r7_side;
    logic signed [eci_pkg::PROD_W-1:0]   r7_p [4];
    eci_pkg::t_sq                        w_x  [4];
    logic signed [eci_pkg::FIELD_W:0]    w_y  [4];
    logic                                r8_vld;
    eci_pkg::t_side                      r8_side;
    eci_pkg::t_sq                        r8_t [4];
    logic                                r_out_vld;
    eci_pkg::t_out                       r_out;
    eci_pkg::t_out                       n_out;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld    <= i_valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r5_vld    <= w_dv_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r_out_vld <= r8_vld;
        end
    end

    // relative velocity and normal projection
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_in  <= i_data;
            r1_rvx <= eci_pkg::sat(eci_pkg::WIDE_W'(i_data.vel_a_x)
                                   - eci_pkg::WIDE_W'(i_data.vel_b_x));
            r1_rvy <= eci_pkg::sat(eci_pkg::WIDE_W'(i_data.vel_a_y)
                                   - eci_pkg::WIDE_W'(i_data.vel_b_y));
            r2_in  <= r1_in;
            r2_px  <= eci_pkg::smul(r1_rvx, (eci_pkg::FIELD_W+1)'(r1_in.normal_x));
            r2_py  <= eci_pkg::smul(r1_rvy, (eci_pkg::FIELD_W+1)'(r1_in.normal_y));
            r3_in  <= r2_in;
            r3_rel <= eci_pkg::sat(eci_pkg::WIDE_W'(r2_px >>> eci_pkg::FRAC_BITS)
                                   + eci_pkg::WIDE_W'(r2_py >>> eci_pkg::FRAC_BITS));
        end
    end

    // classify and pick divider operands
    always_comb begin
        w_den    = eci_pkg::DEN_W'(r3_in.inv_mass_a) + eci_pkg::DEN_W'(r3_in.inv_mass_b);
        w_tot    = eci_pkg::DEN_W'(r3_in.mass_a) + eci_pkg::DEN_W'(r3_in.mass_b);
        w_negrel = (eci_pkg::FIELD_W+1)'(0) - (eci_pkg::FIELD_W+1)'(r3_rel);
        n_side.vax = r3_in.vel_a_x;
        n_side.vay = r3_in.vel_a_y;
        n_side.vbx = r3_in.vel_b_x;
        n_side.vby = r3_in.vel_b_y;
        n_side.nx  = r3_in.normal_x;
        n_side.ny  = r3_in.normal_y;
        n_side.dep = r3_in.depth;
        n_side.ia  = r3_in.inv_mass_a;
        n_side.ib  = r3_in.inv_mass_b;
        n_num2 = eci_pkg::NUM_W'(r3_in.mass_a) << eci_pkg::FRAC_BITS;
        n_den2 = w_tot;
        if (r3_rel < 0) begin
            n_side.kind = (w_den == '0) ? eci_pkg::OUT_DEG : eci_pkg::OUT_IMP;
            n_num1 = eci_pkg::NUM_W'({w_negrel[eci_pkg::FIELD_W-1:0], 1'b0})
                     << eci_pkg::FRAC_BITS;
            n_den1 = w_den;
        end else if (r3_rel == 0) begin
            n_side.kind = (w_tot == '0) ? eci_pkg::OUT_DEG : eci_pkg::OUT_COR;
            n_num1 = eci_pkg::NUM_W'(r3_in.mass_b) << eci_pkg::FRAC_BITS;
            n_den1 = w_tot;
        end else begin
            n_side.kind = eci_pkg::OUT_SEP;
            n_num1 = eci_pkg::NUM_W'(r3_in.mass_b) << eci_pkg::FRAC_BITS;
            n_den1 = w_tot;
        end
    end

    eci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_vld),
        .i_side  (n_side),
        .i_num1  (n_num1),
        .i_den1  (n_den1),
        .i_num2  (n_num2),
        .i_den2  (n_den2),
        .o_valid (w_dv_vld),
        .o_side  (w_dv_side),
        .o_quo1  (w_q1),
        .o_quo2  (w_q2)
    );

    // impulse vector or depth split
    always_comb begin
        w_mag = (w_q1 > eci_pkg::NUM_W'(eci_pkg::SAT_HI)) ?
                eci_pkg::FIELD_W'(eci_pkg::SAT_HI) : w_q1[eci_pkg::FIELD_W-1:0];
        if (w_dv_side.kind == eci_pkg::OUT_IMP) begin
            n5_m0 = eci_pkg::smul(w_dv_side.nx, {1'b0, w_mag});
            n5_m1 = eci_pkg::smul(w_dv_side.ny, {1'b0, w_mag});
        end else begin
            n5_m0 = eci_pkg::smul(w_dv_side.dep, {1'b0, w_q1[eci_pkg::FIELD_W-1:0]});
            n5_m1 = eci_pkg::smul(w_dv_side.dep, {1'b0, w_q2[eci_pkg::FIELD_W-1:0]});
        end
    end

    // per-axis operands
    always_comb begin
        if (r6_side.kind == eci_pkg::OUT_IMP) begin
            w_x[0] = r6_j0;
            w_x[1] = r6_j1;
            w_x[2] = r6_j0;
            w_x[3] = r6_j1;
            w_y[0] = {1'b0, r6_side.ia};
            w_y[1] = {1'b0, r6_side.ia};
            w_y[2] = {1'b0, r6_side.ib};
            w_y[3] = {1'b0, r6_side.ib};
        end else begin
            w_x[0] = r6_side.nx;
            w_x[1] = r6_side.ny;
            w_x[2] = r6_side.nx;
            w_x[3] = r6_side.ny;
            w_y[0] = (eci_pkg::FIELD_W+1)'(r6_j0);
            w_y[1] = (eci_pkg::FIELD_W+1)'(r6_j0);
            w_y[2] = (eci_pkg::FIELD_W+1)'(r6_j1);
            w_y[3] = (eci_pkg::FIELD_W+1)'(r6_j1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_side <= w_dv_side;
            r5_m0   <= n5_m0;
            r5_m1   <= n5_m1;
            r6_side <= r5_side;
            r6_j0   <= eci_pkg::qsat(r5_m0);
            r6_j1   <= eci_pkg::qsat(r5_m1);
            r7_side <= r6_side;
            r8_side <= r7_side;
            for (int i = 0; i < 4; i++) begin
                r7_p[i] <= eci_pkg::smul(w_x[i], w_y[i]);
                r8_t[i] <= eci_pkg::qsat(r7_p[i]);
            end
            r_out   <= n_out;
        end
    end

    // final update
    always_comb begin
        n_out.outcome     = r8_side.kind;
        n_out.new_vel_a_x = eci_pkg::sat(eci_pkg::WIDE_W'(r8_side.vax));
        n_out.new_vel_a_y = eci_pkg::sat(eci_pkg::WIDE_W'(r8_side.vay));
        n_out.new_vel_b_x = eci_pkg::sat(eci_pkg::WIDE_W'(r8_side.vbx));
        n_out.new_vel_b_y = eci_pkg::sat(eci_pkg::WIDE_W'(r8_side.vby));
        n_out.shift_a_x   = '0;
        n_out.shift_a_y   = '0;
        n_out.shift_b_x   = '0;
        n_out.shift_b_y   = '0;
        case (r8_side.kind)
            eci_pkg::OUT_IMP: begin
                n_out.new_vel_a_x = eci_pkg::sat(eci_pkg::WIDE_W'(r8_side.vax)
                                                 + eci_pkg::WIDE_W'(r8_t[0]));
                n_out.new_vel_a_y = eci_pkg::sat(eci_pkg::WIDE_W'(r8_side.vay)
                                                 + eci_pkg::WIDE_W'(r8_t[1]));
                n_out.new_vel_b_x = eci_pkg::sat(eci_pkg::WIDE_W'(r8_side.vbx)
                                                 - eci_pkg::WIDE_W'(r8_t[2]));
                n_out.new_vel_b_y = eci_pkg::sat(eci_pkg::WIDE_W'(r8_side.vby)
                                                 - eci_pkg::WIDE_W'(r8_t[3]));
            end
            eci_pkg::OUT_COR: begin
                n_out.shift_a_x = r8_t[0];
                n_out.shift_a_y = r8_t[1];
                n_out.shift_b_x = eci_pkg::sat(eci_pkg::WIDE_W'(0)
                                               - eci_pkg::WIDE_W'(r8_t[2]));
                n_out.shift_b_y = eci_pkg::sat(eci_pkg::WIDE_W'(0)
                                               - eci_pkg::WIDE_W'(r8_t[3]));
            end
            default: begin
            end
        endcase
    end

    `ECI_ASSERT_IMPL(a_stall_src, i_clk, i_rst_n, o_stall, o_valid && i_stall, "stall without held output")
    `ECI_ASSERT_NEXT(a_front_adv, i_clk, i_rst_n, r1_vld && w_en, r2_vld, "front stage lost a transaction")
    `ECI_ASSERT_IMPL(a_sep_shift, i_clk, i_rst_n, o_valid && (o_data.outcome != eci_pkg::OUT_COR), (o_data.shift_a_x == '0) && (o_data.shift_a_y == '0) && (o_data.shift_b_x == '0) && (o_data.shift_b_y == '0), "shift without correction")

endmodule
`default_nettype wire
